### rtl/bmf_pkg.sv
package bmf_pkg;

  localparam int ROUNDS    = 256;
  localparam int RND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int MIX_DEPTH = 32;
  localparam int MIX_AW    = $clog2(MIX_DEPTH);
  localparam int SW_W      = MIX_AW - 1;
  localparam int SW_LAST   = MIX_DEPTH / 2 - 1;
  localparam int SRC_W     = 128;

  localparam logic [1:0] CHUNK_4 = 2'd0;
  localparam logic [1:0] CHUNK_8 = 2'd1;

  localparam logic [3:0] MASK_4  = 4'd3;
  localparam logic [3:0] MASK_8  = 4'd7;
  localparam logic [3:0] MASK_16 = 4'd15;

  typedef struct packed {
    logic        clear_first;
    logic [1:0]  chunk_size;
    logic [63:0] src_low;
    logic [63:0] src_high;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_word_0;
    logic [63:0] digest_word_1;
    logic [63:0] digest_word_2;
    logic [63:0] digest_word_3;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_SWEEP,
    ST_FLUSH,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic start;
    logic fetch;
    logic update;
    logic sweep;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic rnd_last;
    logic sw_last;
  } sts_t;

  function automatic logic [7:0] src_at(input logic [SRC_W-1:0] src, input logic [3:0] k);
    src_at = src[8*k +: 8];
  endfunction

  function automatic logic [3:0] chunk_mask(input logic [1:0] code);
    logic [3:0] m;
    unique case (code)
      CHUNK_4: m = MASK_4;
      CHUNK_8: m = MASK_8;
      default: m = MASK_16;
    endcase
    chunk_mask = m;
  endfunction

endpackage

### rtl/bmf_ctrl.sv
module bmf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bmf_pkg::sts_t  sts,
  output bmf_pkg::cmd_t  cmd
);

  bmf_pkg::state_t state, state_next;
  logic            out_vld, out_vld_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bmf_pkg::ST_IDLE;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      out_vld <= out_vld_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bmf_pkg::ST_IDLE: begin
        if (in_valid) state_next = bmf_pkg::ST_FETCH;
      end
      bmf_pkg::ST_FETCH: begin
        state_next = bmf_pkg::ST_UPDATE;
      end
      bmf_pkg::ST_UPDATE: begin
        state_next = sts.rnd_last ? bmf_pkg::ST_SWEEP : bmf_pkg::ST_FETCH;
      end
      bmf_pkg::ST_SWEEP: begin
        if (sts.sw_last) state_next = bmf_pkg::ST_FLUSH;
      end
      bmf_pkg::ST_FLUSH: begin
        state_next = bmf_pkg::ST_DELIVER;
      end
      bmf_pkg::ST_DELIVER: begin
        if (!out_vld || out_ready) state_next = bmf_pkg::ST_IDLE;
      end
      default: state_next = bmf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      bmf_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      bmf_pkg::ST_FETCH:   cmd.fetch  = 1'b1;
      bmf_pkg::ST_UPDATE:  cmd.update = 1'b1;
      bmf_pkg::ST_SWEEP:   cmd.sweep  = 1'b1;
      bmf_pkg::ST_FLUSH:   cmd        = '0;
      bmf_pkg::ST_DELIVER: cmd.load_out = !out_vld || out_ready;
      default:             cmd        = '0;
    endcase
  end

  always_comb begin
    out_vld_next = out_vld;
    if (out_vld && out_ready) out_vld_next = 1'b0;
    if (cmd.load_out) out_vld_next = 1'b1;
  end

  assign out_valid = out_vld;

  a_start_fetch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == bmf_pkg::ST_FETCH))
    else $error("request accepted without starting a round");

  a_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == bmf_pkg::ST_UPDATE && sts.rnd_last) |=> (state == bmf_pkg::ST_SWEEP))
    else $error("last round not followed by readout");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_vld)
    else $error("result loaded but not presented");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.fetch, cmd.update, cmd.sweep, cmd.load_out}))
    else $error("more than one datapath command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_ready) |-> !cmd.load_out)
    else $error("pending result overwritten");

endmodule

### rtl/bmf_datapath.sv
module bmf_datapath (
  input  logic           clk,
  input  logic           rst,
  input  bmf_pkg::in_t   in_data,
  input  bmf_pkg::cmd_t  cmd,
  output bmf_pkg::sts_t  sts,
  output bmf_pkg::out_t  out_data
);

  logic [7:0]                   mem [bmf_pkg::MIX_DEPTH];
  logic [bmf_pkg::MIX_DEPTH-1:0] vld;

  logic [bmf_pkg::SRC_W-1:0]    src_q;
  logic [3:0]                   mask_q;
  logic [7:0]                   acc_q;
  logic [bmf_pkg::RND_W-1:0]    rnd_q;
  logic [bmf_pkg::MIX_AW-1:0]   t_q;
  logic [bmf_pkg::SW_W-1:0]     sw_q;
  logic                         cap_q;
  logic [bmf_pkg::SW_W-1:0]     cap_idx_q;
  logic [7:0]                   rd0_q, rd1_q;
  logic                         rv0_q, rv1_q;
  logic [8*bmf_pkg::MIX_DEPTH-1:0] dig_buf;
  bmf_pkg::out_t                out_q;

  logic [7:0]                 r8, diff, tsum, usum, mixd, mixt, sub_b, new_b;
  logic [3:0]                 sidx, uidx;
  logic [bmf_pkg::MIX_AW-1:0] t_calc, ra0, ra1;

  always_comb begin
    r8     = 8'(rnd_q);
    diff   = r8 - acc_q;
    sidx   = diff[3:0] & mask_q;
    tsum   = r8 + acc_q + bmf_pkg::src_at(src_q, sidx);
    t_calc = tsum[bmf_pkg::MIX_AW-1:0];
    mixd   = rv0_q ? rd0_q : 8'd0;
    mixt   = rv1_q ? rd1_q : 8'd0;
    usum   = r8 + acc_q + mixd;
    uidx   = usum[3:0] & mask_q;
    sub_b  = bmf_pkg::src_at(src_q, uidx) ^ 8'h01;
    new_b  = mixt - sub_b;
    if (cmd.sweep) begin
      ra0 = {sw_q, 1'b0};
      ra1 = {sw_q, 1'b1};
    end else begin
      ra0 = diff[bmf_pkg::MIX_AW-1:0];
      ra1 = t_calc;
    end
  end

  // state memory, two registered read ports
  always_ff @(posedge clk) begin
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
    if (cmd.update) mem[t_q] <= new_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      cap_q <= 1'b0;
    end else begin
      if (cmd.start && in_data.clear_first) vld <= '0;
      else if (cmd.update) vld[t_q] <= 1'b1;
      cap_q <= cmd.sweep;
    end
  end

  always_ff @(posedge clk) begin
    rv0_q <= vld[ra0];
    rv1_q <= vld[ra1];
    cap_idx_q <= sw_q;
    if (cmd.start) begin
      src_q  <= {in_data.src_high, in_data.src_low};
      mask_q <= bmf_pkg::chunk_mask(in_data.chunk_size);
      acc_q  <= 8'd0;
      rnd_q  <= '0;
      sw_q   <= '0;
    end
    if (cmd.fetch) t_q <= t_calc;
    if (cmd.update) begin
      acc_q <= new_b;
      rnd_q <= rnd_q + 1'b1;
    end
    if (cmd.sweep) sw_q <= sw_q + 1'b1;
    if (cap_q) dig_buf[16*cap_idx_q +: 16] <= {(rv1_q ? rd1_q : 8'd0), (rv0_q ? rd0_q : 8'd0)};
    if (cmd.load_out) begin
      out_q.digest_word_0 <= dig_buf[63:0];
      out_q.digest_word_1 <= dig_buf[127:64];
      out_q.digest_word_2 <= dig_buf[191:128];
      out_q.digest_word_3 <= dig_buf[255:192];
    end
  end

  assign sts.rnd_last = (rnd_q == bmf_pkg::RND_W'(bmf_pkg::ROUNDS - 1));
  assign sts.sw_last  = (sw_q == bmf_pkg::SW_W'(bmf_pkg::SW_LAST));
  assign out_data     = out_q;

endmodule

### rtl/byte_mix_fingerprint.sv
// byte_mix_fingerprint keeps a 32-byte mixing state in a small two-read-port
// memory and absorbs one chunk of 4, 8 or 16 source bytes per request, then
// returns the whole state as four 64-bit words. Each of the ROUNDS rounds
// has a read step (FETCH) for the two state bytes the round depends on and
// a write step (UPDATE) for the updated byte, because every round needs the
// accumulator and memory contents left by the one before. After the rounds
// the state is read out two bytes a cycle. A new request is taken only once
// the previous result is loaded into the output register; that result can
// wait there while the next request runs. Clearing the state, at reset or by
// clear_first, clears per-byte valid flags; unflagged bytes read as zero.
module byte_mix_fingerprint (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bmf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bmf_pkg::out_t out_data
);

  bmf_pkg::cmd_t cmd;
  bmf_pkg::sts_t sts;

  bmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmf_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
